FILE: hw/rtl/pid_vector_controller_assert.svh
// Assertion macros for the checker file pvc_checker.sv.
`ifndef PID_VECTOR_CONTROLLER_ASSERT_SVH
`define PID_VECTOR_CONTROLLER_ASSERT_SVH

// ante true at an edge -> cons true at the next edge
`define PVC_ASSERT_NEXT(lbl, ck, dis, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (dis) (ante) |=> (cons)) \
    else $error("pid_vector_controller: next-cycle check failed");

// ante true at an edge -> cons true at the same edge
`define PVC_ASSERT_IMPL(lbl, ck, dis, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (dis) (ante) |-> (cons)) \
    else $error("pid_vector_controller: same-cycle check failed");

`endif

FILE: hw/rtl/pvc_pkg.sv
`timescale 1ns / 1ps
package pvc_pkg;

  localparam int AXIS_COUNT = 3;
  localparam int FIELD_AXES = 3;
  localparam int AXIS_W     = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

  localparam int IN_W       = 2 * FIELD_AXES * 32;
  localparam int RES_W      = FIELD_AXES * 32 + 2;
  localparam int OUT_W      = ((RES_W + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_KP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIME = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RATE = 3'd4;

  localparam logic [15:0] STEP_TIME_RESET = 16'd655;
  localparam logic [31:0] STEP_RATE_RESET = 32'd6553600;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_CHK  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_ERR  = 4'd1;
  localparam logic [STEP_W-1:0] STEP_M0   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_M1   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_M2   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_M3   = 4'd5;
  localparam logic [STEP_W-1:0] STEP_M4   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_M5   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_M6   = 4'd8;
  localparam logic [STEP_W-1:0] STEP_ACC  = 4'd9;
  localparam logic [STEP_W-1:0] STEP_FRC  = 4'd10;
  localparam logic [STEP_W-1:0] STEP_DONE = 4'd11;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_ERR_DT,
    MUL_DIFF_RATE,
    MUL_KP_ERR,
    MUL_KI_IHI,
    MUL_KI_ILO,
    MUL_KD_DHI,
    MUL_KD_DLO
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_ADD_SH
  } acc_op_t;

  typedef enum logic [2:0] {
    WB_NONE,
    WB_CHECK,
    WB_ERR,
    WB_INTEG,
    WB_DERIV,
    WB_FORCE
  } wb_op_t;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_LOOP,
    SEQ_DONE
  } seq_op_t;

  typedef struct packed {
    mul_sel_t          mul_sel;
    acc_op_t           acc_op;
    wb_op_t            wb_op;
    seq_op_t           seq_op;
    logic [STEP_W-1:0] jump;
  } ucode_t;

  typedef struct packed {
    mul_sel_t          mul_sel;
    acc_op_t           acc_op;
    wb_op_t            wb_op;
    logic [AXIS_W-1:0] axis;
    logic              load_out;
  } ctrl_t;

  typedef struct packed {
    logic        target_changed;
    logic        saturated;
    logic [31:0] force_z;
    logic [31:0] force_y;
    logic [31:0] force_x;
  } result_t;

  function automatic ucode_t uc(mul_sel_t m, acc_op_t a, wb_op_t w, seq_op_t s,
                                logic [STEP_W-1:0] j);
    ucode_t r;
    r.mul_sel = m;
    r.acc_op  = a;
    r.wb_op   = w;
    r.seq_op  = s;
    r.jump    = j;
    return r;
  endfunction

  // One axis runs STEP_ERR..STEP_FRC; products land in the step after issue.
  function automatic ucode_t ucode_rom(logic [STEP_W-1:0] step);
    ucode_t w;
    case (step)
      STEP_CHK:  w = uc(MUL_NONE,      ACC_HOLD,   WB_CHECK, SEQ_NEXT, STEP_CHK);
      STEP_ERR:  w = uc(MUL_NONE,      ACC_HOLD,   WB_ERR,   SEQ_NEXT, STEP_CHK);
      STEP_M0:   w = uc(MUL_ERR_DT,    ACC_HOLD,   WB_NONE,  SEQ_NEXT, STEP_CHK);
      STEP_M1:   w = uc(MUL_DIFF_RATE, ACC_HOLD,   WB_INTEG, SEQ_NEXT, STEP_CHK);
      STEP_M2:   w = uc(MUL_KP_ERR,    ACC_HOLD,   WB_DERIV, SEQ_NEXT, STEP_CHK);
      STEP_M3:   w = uc(MUL_KI_IHI,    ACC_LOAD,   WB_NONE,  SEQ_NEXT, STEP_CHK);
      STEP_M4:   w = uc(MUL_KI_ILO,    ACC_ADD_SH, WB_NONE,  SEQ_NEXT, STEP_CHK);
      STEP_M5:   w = uc(MUL_KD_DHI,    ACC_ADD,    WB_NONE,  SEQ_NEXT, STEP_CHK);
      STEP_M6:   w = uc(MUL_KD_DLO,    ACC_ADD_SH, WB_NONE,  SEQ_NEXT, STEP_CHK);
      STEP_ACC:  w = uc(MUL_NONE,      ACC_ADD,    WB_NONE,  SEQ_NEXT, STEP_CHK);
      STEP_FRC:  w = uc(MUL_NONE,      ACC_HOLD,   WB_FORCE, SEQ_LOOP, STEP_ERR);
      STEP_DONE: w = uc(MUL_NONE,      ACC_HOLD,   WB_NONE,  SEQ_DONE, STEP_CHK);
      default:   w = uc(MUL_NONE,      ACC_HOLD,   WB_NONE,  SEQ_DONE, STEP_CHK);
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/pvc_sequencer.sv
`timescale 1ns / 1ps
module pvc_sequencer (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          out_free,
  output logic          busy,
  output pvc_pkg::ctrl_t ctrl
);
  import pvc_pkg::*;

  localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(AXIS_COUNT - 1);

  logic [STEP_W-1:0] step;
  logic [AXIS_W-1:0] axis;
  ucode_t            word;

  assign word = ucode_rom(step);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= STEP_CHK;
      axis <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= STEP_CHK;
      axis <= '0;
    end else if (busy) begin
      case (word.seq_op)
        SEQ_NEXT: step <= step + 1'b1;
        SEQ_LOOP: begin
          if (axis != AXIS_LAST) begin
            axis <= axis + 1'b1;
            step <= word.jump;
          end else begin
            step <= step + 1'b1;
          end
        end
        SEQ_DONE: begin
          if (out_free) begin
            busy <= 1'b0;
          end
        end
        default: busy <= 1'b0;
      endcase
    end
  end

  always_comb begin
    ctrl.mul_sel  = busy ? word.mul_sel : MUL_NONE;
    ctrl.acc_op   = busy ? word.acc_op : ACC_HOLD;
    ctrl.wb_op    = busy ? word.wb_op : WB_NONE;
    ctrl.axis     = axis;
    ctrl.load_out = busy && (word.seq_op == SEQ_DONE) && out_free;
  end

endmodule

FILE: hw/rtl/pvc_datapath.sv
`timescale 1ns / 1ps
module pvc_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [pvc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pvc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            load_in,
  input  logic [pvc_pkg::IN_W-1:0]        in_data,
  input  pvc_pkg::ctrl_t                  ctrl,
  output pvc_pkg::result_t                result
);
  import pvc_pkg::*;

  logic signed [31:0] kp, ki, kd;
  logic [15:0]        step_time;
  logic [31:0]        step_rate;

  logic signed [31:0] cur    [AXIS_COUNT];
  logic signed [31:0] goal   [AXIS_COUNT];
  logic signed [31:0] stored [AXIS_COUNT];
  logic signed [47:0] integ  [AXIS_COUNT];
  logic signed [31:0] prev   [AXIS_COUNT];
  logic [31:0]        force_v [FIELD_AXES];

  logic signed [31:0] err;
  logic signed [47:0] deriv;
  logic signed [65:0] prod;
  logic signed [83:0] acc;
  logic               clip;
  logic               changed;

  logic signed [31:0] cur_a, goal_a, prev_a;
  logic signed [47:0] integ_a;
  logic signed [32:0] ma, mb;
  logic [32:0]        err_d;
  logic               err_ovf;
  logic [31:0]        err_sat;
  logic [65:0]        prod_rnd;
  logic [49:0]        p_r;
  logic [50:0]        int_sum;
  logic               int_ovf;
  logic [47:0]        int_sat;
  logic               der_ovf;
  logic [47:0]        der_sat;
  logic [83:0]        acc_rnd;
  logic [67:0]        f_w;
  logic               f_ovf;
  logic [31:0]        f_sat;
  logic               chg;

  assign cur_a   = cur[ctrl.axis];
  assign goal_a  = goal[ctrl.axis];
  assign prev_a  = prev[ctrl.axis];
  assign integ_a = integ[ctrl.axis];

  // error, saturated to 32 bits
  assign err_d   = {goal_a[31], goal_a} - {cur_a[31], cur_a};
  assign err_ovf = err_d[32] != err_d[31];
  assign err_sat = err_ovf ? (err_d[32] ? 32'h8000_0000 : 32'h7fff_ffff) : err_d[31:0];

  // Q.16 rounding of the registered product
  assign prod_rnd = prod + 66'd32768;
  assign p_r      = prod_rnd[65:16];

  assign int_sum = {{3{integ_a[47]}}, integ_a} + {p_r[49], p_r};
  assign int_ovf = !((&int_sum[50:47]) || (~|int_sum[50:47]));
  assign int_sat = int_ovf ? (int_sum[50] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}})
                           : int_sum[47:0];

  assign der_ovf = !((&p_r[49:47]) || (~|p_r[49:47]));
  assign der_sat = der_ovf ? (p_r[49] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}})
                           : p_r[47:0];

  assign acc_rnd = acc + 84'd32768;
  assign f_w     = acc_rnd[83:16];
  assign f_ovf   = !((&f_w[67:31]) || (~|f_w[67:31]));
  assign f_sat   = f_ovf ? (f_w[67] ? 32'h8000_0000 : 32'h7fff_ffff) : f_w[31:0];

  always_comb begin
    chg = 1'b0;
    for (int k = 0; k < AXIS_COUNT; k++) begin
      if (goal[k] != stored[k]) chg = 1'b1;
    end
  end

  // operand select for the shared 33x33 multiplier
  always_comb begin
    case (ctrl.mul_sel)
      MUL_ERR_DT: begin
        ma = {err[31], err};
        mb = {17'b0, step_time};
      end
      MUL_DIFF_RATE: begin
        ma = {err[31], err} - {prev_a[31], prev_a};
        mb = {1'b0, step_rate};
      end
      MUL_KP_ERR: begin
        ma = {kp[31], kp};
        mb = {err[31], err};
      end
      MUL_KI_IHI: begin
        ma = {ki[31], ki};
        mb = {integ_a[47], integ_a[47:16]};
      end
      MUL_KI_ILO: begin
        ma = {ki[31], ki};
        mb = {17'b0, integ_a[15:0]};
      end
      MUL_KD_DHI: begin
        ma = {kd[31], kd};
        mb = {deriv[47], deriv[47:16]};
      end
      MUL_KD_DLO: begin
        ma = {kd[31], kd};
        mb = {17'b0, deriv[15:0]};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kp        <= '0;
      ki        <= '0;
      kd        <= '0;
      step_time <= STEP_TIME_RESET;
      step_rate <= STEP_RATE_RESET;
      for (int k = 0; k < AXIS_COUNT; k++) begin
        stored[k] <= '0;
        integ[k]  <= '0;
        prev[k]   <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_KP:   kp <= cfg_data;
          REG_KI:   ki <= cfg_data;
          REG_KD:   kd <= cfg_data;
          REG_TIME: step_time <= cfg_data[15:0];
          REG_RATE: step_rate <= cfg_data;
          default: ;
        endcase
      end
      case (ctrl.wb_op)
        WB_CHECK: begin
          if (chg) begin
            for (int k = 0; k < AXIS_COUNT; k++) begin
              stored[k] <= goal[k];
              integ[k]  <= '0;
              prev[k]   <= '0;
            end
          end
        end
        WB_INTEG: integ[ctrl.axis] <= int_sat;
        WB_FORCE: prev[ctrl.axis] <= err;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_in) begin
      for (int k = 0; k < AXIS_COUNT; k++) begin
        cur[k]  <= in_data[k*32 +: 32];
        goal[k] <= in_data[(FIELD_AXES + k)*32 +: 32];
      end
    end
    prod <= ma * mb;
    case (ctrl.acc_op)
      ACC_LOAD:   acc <= {{18{prod[65]}}, prod};
      ACC_ADD:    acc <= acc + {{18{prod[65]}}, prod};
      ACC_ADD_SH: acc <= acc + {{2{prod[65]}}, prod, 16'b0};
      default: ;
    endcase
    case (ctrl.wb_op)
      WB_CHECK: begin
        changed <= chg;
        clip    <= 1'b0;
        for (int k = 0; k < FIELD_AXES; k++) begin
          force_v[k] <= '0;
        end
      end
      WB_ERR: begin
        err <= err_sat;
        if (err_ovf) clip <= 1'b1;
      end
      WB_INTEG: begin
        if (int_ovf) clip <= 1'b1;
      end
      WB_DERIV: begin
        deriv <= der_sat;
        if (der_ovf) clip <= 1'b1;
      end
      WB_FORCE: begin
        force_v[ctrl.axis] <= f_sat;
        if (f_ovf) clip <= 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    result.force_x        = force_v[0];
    result.force_y        = force_v[1];
    result.force_z        = force_v[2];
    result.saturated      = clip;
    result.target_changed = changed;
  end

endmodule

FILE: hw/rtl/pid_vector_controller.sv
`timescale 1ns / 1ps
// channel   dir  handshake           payload
// s_axis    in   s_tvalid/s_tready   s_tdata: current_x,y,z, goal_x,y,z
// m_axis    out  m_tvalid/m_tready   m_tdata: force_x,y,z, saturated, target_changed
// cfg       in   cfg_wr_en           cfg_index, cfg_data
//
// From acceptance to a valid result a word runs the whole microprogram;
// one 33x33 multiplier serves the seven products of each axis.
// s_tready is low while the microprogram runs and rises at the same edge that
// loads the result register. A stalled result holds the program in its last step.
// Reset (rst, synchronous) clears gains, sets step_time 655 and step_rate
// 6553600, and zeroes the target, integral and previous-error stores.
module pid_vector_controller (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [pvc_pkg::IN_W-1:0]       s_tdata,  // current_x, current_y, current_z,
                                                   // goal_x, goal_y, goal_z
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [pvc_pkg::OUT_W-1:0]      m_tdata,  // force_x, force_y, force_z,
                                                   // saturated, target_changed, pad
  input  logic                           cfg_wr_en,
  input  logic [pvc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pvc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pvc_pkg::*;

  logic    busy;
  logic    start;
  logic    out_free;
  ctrl_t   ctrl;
  result_t result;

  assign s_tready = !busy;
  assign start    = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  pvc_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .out_free (out_free),
    .busy     (busy),
    .ctrl     (ctrl)
  );

  pvc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .load_in   (start),
    .in_data   (s_tdata),
    .ctrl      (ctrl),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      m_tdata <= {{(OUT_W - RES_W){1'b0}}, result};
    end
  end

endmodule

FILE: hw/rtl/pvc_checker.sv
`timescale 1ns / 1ps
`include "pid_vector_controller_assert.svh"
module pvc_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     s_tvalid,
  input logic                     s_tready,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic [pvc_pkg::OUT_W-1:0] m_tdata
);
  import pvc_pkg::*;

  `PVC_ASSERT_NEXT(a_reset_idle, clk, 1'b0, rst, !m_tvalid && s_tready)
  `PVC_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `PVC_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)
  `PVC_ASSERT_IMPL(a_result_from_work, clk, rst, $rose(m_tvalid), !$past(s_tready))

endmodule

bind pid_vector_controller pvc_checker u_pvc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
